### rtl/pbdpf_pkg.sv
// Package of the polar bin dynamic point filter: sizes, codes, register and
// bin types, the controller/datapath command and status structs, CORDIC table.
// Depends on nothing.
`timescale 1ns / 1ps

package pbdpf_pkg;

  localparam int RINGS   = 20;
  localparam int SECTORS = 60;
  localparam int NBINS   = RINGS * SECTORS;
  localparam int ADDR_W  = $clog2(NBINS);

  localparam int COORD_W = 20;
  localparam int RANGE_W = 19;
  localparam int CNT_W   = 16;
  localparam int RING_W  = 5;
  localparam int SECT_W  = 6;
  localparam int DEC_W   = 3;
  localparam int THR_W   = 9;

  localparam int CORDIC_STEPS = 24;
  localparam int SQRT_STEPS   = 20;
  localparam int CORDIC_W     = 47;
  localparam int ANG_W        = 32;
  localparam int SPROD_W      = ANG_W + 10;
  localparam int D2_W         = 40;
  localparam int ROOT_W       = 20;
  localparam int ACC_W        = RANGE_W + RING_W + 1;
  localparam int STEP_W       = ADDR_W;
  localparam int SPREAD_W     = COORD_W + 1;
  localparam int RATIO_W      = 31;

  localparam logic [ANG_W-1:0] HALF_TURN  = 32'h8000_0000;
  localparam logic [ANG_W-1:0] QTR_TURN   = 32'h4000_0000;
  localparam logic [ANG_W-1:0] THREE_QTR  = 32'hC000_0000;
  localparam logic [ANG_W-1:0] FULL_ANGLE = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_ADD_SCAN = 2'd1,
    CMD_ADD_MAP  = 2'd2,
    CMD_QUERY    = 2'd3
  } cmd_e;

  typedef enum logic [DEC_W-1:0] {
    DEC_EMPTY  = 3'd0,
    DEC_MAP    = 3'd1,
    DEC_SCAN   = 3'd2,
    DEC_MERGE  = 3'd3,
    DEC_GROUND = 3'd4
  } dec_e;

  typedef enum logic [2:0] {
    REG_RANGE_LIMIT      = 3'd0,
    REG_RING_WIDTH       = 3'd1,
    REG_HEIGHT_UPPER     = 3'd2,
    REG_HEIGHT_LOWER     = 3'd3,
    REG_MIN_SCAN_POINTS  = 3'd4,
    REG_RATIO_THRESHOLD  = 3'd5,
    REG_BIN_HEIGHT_LIMIT = 3'd6
  } reg_e;

  typedef enum logic [1:0] {
    MUL_X = 2'd0,
    MUL_Y = 2'd1,
    MUL_R = 2'd2
  } mul_sel_e;

  typedef enum logic [3:0] {
    S_BOOT, S_IDLE, S_CLR, S_MULX, S_MULY, S_MULR, S_CHECK,
    S_ITER, S_RING, S_SECT, S_RD, S_WR, S_QCHK, S_DONE
  } state_e;

  typedef struct packed {
    logic [RANGE_W-1:0]        range_limit;
    logic [RANGE_W-1:0]        ring_width;
    logic signed [COORD_W-1:0] height_upper;
    logic signed [COORD_W-1:0] height_lower;
    logic [CNT_W-1:0]          min_scan_points;
    logic [THR_W-1:0]          ratio_threshold;
    logic signed [COORD_W-1:0] bin_height_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    range_limit:      19'd20480,
    ring_width:       19'd1024,
    height_upper:     20'sd768,
    height_lower:     -20'sd256,
    min_scan_points:  16'd5,
    ratio_threshold:  9'd51,
    bin_height_limit: 20'sd0
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] bottom;
    logic [CNT_W-1:0]          count;
  } bin_t;

  localparam int BIN_W = $bits(bin_t);

  localparam bin_t BIN_RESET = '{
    top:    {1'b1, {(COORD_W-1){1'b0}}},
    bottom: {1'b0, {(COORD_W-1){1'b1}}},
    count:  '0
  };

  typedef struct packed {
    logic              load_in;
    logic              mul_en;
    mul_sel_e          mul_sel;
    logic              chk_en;
    logic              iter_init;
    logic              iter_step;
    logic              ring_init;
    logic              ring_step;
    logic              sect_en;
    logic              ram_rd;
    logic              upd_wr;
    logic              clr_wr;
    logic              res_load;
    logic [STEP_W-1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e command;
    logic in_band;
    logic q_in_grid;
    logic ring_done;
    logic out_free;
  } dp_stat_t;

  // atan(2^-i) as a 32-bit fraction of a full turn.
  function automatic logic [ANG_W-1:0] atan_turn(input logic [4:0] i);
    logic [ANG_W-1:0] a;
    unique case (i)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### rtl/pbdpf_in_if.sv
// Input channel of the point filter: handshake plus one command beat.
// Depends on pbdpf_pkg.
`timescale 1ns / 1ps

interface pbdpf_in_if import pbdpf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                command;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  logic [RING_W-1:0]         query_ring;
  logic [SECT_W-1:0]         query_sector;

  modport source (output valid, command, point_x, point_y, point_z, query_ring,
                  query_sector, input ready);
  modport sink (input valid, command, point_x, point_y, point_z, query_ring,
                query_sector, output ready);
endinterface

### rtl/pbdpf_out_if.sv
// Result channel of the point filter: handshake plus one result beat.
// Depends on pbdpf_pkg.
`timescale 1ns / 1ps

interface pbdpf_out_if import pbdpf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              accepted;
  logic [RING_W-1:0] bin_ring;
  logic [SECT_W-1:0] bin_sector;
  logic [DEC_W-1:0]  decision;
  logic [CNT_W-1:0]  scan_points;
  logic [CNT_W-1:0]  map_points;

  modport source (output valid, accepted, bin_ring, bin_sector, decision, scan_points,
                  map_points, input ready);
  modport sink (input valid, accepted, bin_ring, bin_sector, decision, scan_points,
                map_points, output ready);
endinterface

### rtl/polar_bin_dynamic_point_filter_unit.sv
// Top level of the polar bin dynamic point filter: APB register file plus the
// controller and datapath. Depends on pbdpf_pkg, the channel interfaces,
// pbdpf_ctrl and pbdpf_dp.
`timescale 1ns / 1ps

// One command beat is taken at a time and gives one result beat. An add point
// beat runs through the shared squarer (x, then y, then the range limit), one
// range and band check, CORDIC vectoring (the square root runs alongside), the
// ring search, the sector, then a read-modify-write of the bin memory and the
// result load; a point outside the band goes from the check to the result load.
// A query makes one memory read, if its bin lies in the grid. A clear command,
// and the sweep after reset, write all 1200 bins one per cycle; the input is not
// ready until the sweep after reset is done. A finished result waits in the
// output register while the next beat is worked on; the next result is loaded
// only once it has been taken.
module polar_bin_dynamic_point_filter_unit import pbdpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  pbdpf_in_if.sink    in_i,
  pbdpf_out_if.source out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg_q;
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        REG_RANGE_LIMIT:      cfg_q.range_limit      <= pwdata[RANGE_W-1:0];
        REG_RING_WIDTH:       cfg_q.ring_width       <= pwdata[RANGE_W-1:0];
        REG_HEIGHT_UPPER:     cfg_q.height_upper     <= signed'(pwdata[COORD_W-1:0]);
        REG_HEIGHT_LOWER:     cfg_q.height_lower     <= signed'(pwdata[COORD_W-1:0]);
        REG_MIN_SCAN_POINTS:  cfg_q.min_scan_points  <= pwdata[CNT_W-1:0];
        REG_RATIO_THRESHOLD:  cfg_q.ratio_threshold  <= pwdata[THR_W-1:0];
        REG_BIN_HEIGHT_LIMIT: cfg_q.bin_height_limit <= signed'(pwdata[COORD_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_RANGE_LIMIT:      prdata = 32'(cfg_q.range_limit);
      REG_RING_WIDTH:       prdata = 32'(cfg_q.ring_width);
      REG_HEIGHT_UPPER:     prdata = 32'(unsigned'(cfg_q.height_upper));
      REG_HEIGHT_LOWER:     prdata = 32'(unsigned'(cfg_q.height_lower));
      REG_MIN_SCAN_POINTS:  prdata = 32'(cfg_q.min_scan_points);
      REG_RATIO_THRESHOLD:  prdata = 32'(cfg_q.ratio_threshold);
      REG_BIN_HEIGHT_LIMIT: prdata = 32'(unsigned'(cfg_q.bin_height_limit));
      default:              prdata = '0;
    endcase
  end

  pbdpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  pbdpf_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .stat_o         (dp_stat),
    .cfg_i          (cfg_q),
    .command_i      (in_i.command),
    .point_x_i      (in_i.point_x),
    .point_y_i      (in_i.point_y),
    .point_z_i      (in_i.point_z),
    .query_ring_i   (in_i.query_ring),
    .query_sector_i (in_i.query_sector),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .accepted_o     (out_o.accepted),
    .bin_ring_o     (out_o.bin_ring),
    .bin_sector_o   (out_o.bin_sector),
    .decision_o     (out_o.decision),
    .scan_points_o  (out_o.scan_points),
    .map_points_o   (out_o.map_points)
  );

endmodule

### rtl/pbdpf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module pbdpf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### rtl/pbdpf_dp.sv
// Datapath of the point filter: shared squarer, CORDIC, integer square root,
// ring search, bin memories, decision logic and the result register.
// Depends on pbdpf_pkg and pbdpf_ram.
`timescale 1ns / 1ps

module pbdpf_dp import pbdpf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dp_cmd_t                   cmd_i,
  output dp_stat_t                  stat_o,
  input  cfg_t                      cfg_i,
  input  logic [1:0]                command_i,
  input  logic signed [COORD_W-1:0] point_x_i,
  input  logic signed [COORD_W-1:0] point_y_i,
  input  logic signed [COORD_W-1:0] point_z_i,
  input  logic [RING_W-1:0]         query_ring_i,
  input  logic [SECT_W-1:0]         query_sector_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic                      accepted_o,
  output logic [RING_W-1:0]         bin_ring_o,
  output logic [SECT_W-1:0]         bin_sector_o,
  output logic [DEC_W-1:0]          decision_o,
  output logic [CNT_W-1:0]          scan_points_o,
  output logic [CNT_W-1:0]          map_points_o
);

  cmd_e                       cmd_q;
  logic signed [COORD_W-1:0]  x_q, y_q, z_q;
  logic [RING_W-1:0]          qr_q;
  logic [SECT_W-1:0]          qs_q;
  logic [D2_W-1:0]            d2_q, rr_q;
  logic                       ok_q;

  logic signed [COORD_W:0]    mul_a;
  logic signed [2*COORD_W+1:0] mul_p;

  logic [D2_W-1:0]            sq_v_q, sq_res_q;
  logic [D2_W-1:0]            sq_bit, sq_sum;
  logic [5:0]                 sq_sh;

  logic signed [CORDIC_W-1:0] cx_q, cy_q, cx_init, cy_init, dx, dy;
  logic [ANG_W-1:0]           ang_q;
  logic [4:0]                 cstep;

  logic [RING_W-1:0]          ring_q;
  logic [ACC_W-1:0]           acc_q;
  logic                       ring_go;

  logic [ANG_W-1:0]           fa;
  logic [SPROD_W-1:0]         sprod;
  logic [9:0]                 sec_raw;
  logic [SECT_W-1:0]          sector_q;

  logic [ADDR_W-1:0]          bin_addr, q_addr, rd_addr, wr_addr;
  bin_t                       scan_rd, map_rd, cur, upd;
  logic                       scan_we, map_we;
  bin_t                       scan_wd, map_wd;

  logic signed [SPREAD_W-1:0] md, sd, lo, hi;
  logic signed [RATIO_W-1:0]  lhs, rhs;
  dec_e                       dec;

  logic                       is_add, q_in_grid;
  logic                       out_valid_q;

  // Shared squarer: x, then y, then the range limit.
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_X:   mul_a = (COORD_W+1)'(x_q);
      MUL_Y:   mul_a = (COORD_W+1)'(y_q);
      MUL_R:   mul_a = signed'({2'b00, cfg_i.range_limit});
      default: mul_a = '0;
    endcase
    mul_p = mul_a * mul_a;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q <= cmd_e'(command_i);
      x_q   <= point_x_i;
      y_q   <= point_y_i;
      z_q   <= point_z_i;
      qr_q  <= query_ring_i;
      qs_q  <= query_sector_i;
    end
    if (cmd_i.mul_en) begin
      unique case (cmd_i.mul_sel)
        MUL_X:   d2_q <= D2_W'(mul_p);
        MUL_Y:   d2_q <= d2_q + D2_W'(mul_p);
        MUL_R:   rr_q <= D2_W'(mul_p);
        default: ;
      endcase
    end
    if (cmd_i.chk_en) begin
      ok_q <= stat_o.in_band;
    end
  end

  // Square root, one result bit (two bits of the radicand) per step.
  assign sq_sh  = 6'(2 * (SQRT_STEPS - 1)) - {cmd_i.step[4:0], 1'b0};
  assign sq_bit = D2_W'(1) << sq_sh;
  assign sq_sum = sq_res_q + sq_bit;

  // CORDIC vectoring; a negative x is pre-rotated by a half turn.
  assign cx_init = CORDIC_W'(x_q) <<< 24;
  assign cy_init = CORDIC_W'(y_q) <<< 24;
  assign cstep   = cmd_i.step[4:0];
  assign dx      = cy_q >>> cstep;
  assign dy      = cx_q >>> cstep;

  always_ff @(posedge clk_i) begin
    if (cmd_i.iter_init) begin
      sq_v_q   <= d2_q;
      sq_res_q <= '0;
      if (x_q < 0) begin
        cx_q  <= -cx_init;
        cy_q  <= -cy_init;
        ang_q <= HALF_TURN;
      end else begin
        cx_q  <= cx_init;
        cy_q  <= cy_init;
        ang_q <= '0;
      end
    end else if (cmd_i.iter_step) begin
      if (cy_q > 0) begin
        cx_q  <= cx_q + dx;
        cy_q  <= cy_q - dy;
        ang_q <= ang_q + atan_turn(cstep);
      end else begin
        cx_q  <= cx_q - dx;
        cy_q  <= cy_q + dy;
        ang_q <= ang_q - atan_turn(cstep);
      end
      if (cmd_i.step < STEP_W'(SQRT_STEPS)) begin
        if (sq_v_q >= sq_sum) begin
          sq_v_q   <= sq_v_q - sq_sum;
          sq_res_q <= (sq_res_q >> 1) + sq_bit;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
      end
    end
  end

  // Ring search: count the ring boundaries that lie at or below the radius, up to RINGS - 1.
  assign ring_go = (ring_q < RING_W'(RINGS - 1)) &&
                   (acc_q <= ACC_W'(sq_res_q[ROOT_W-1:0]));

  always_ff @(posedge clk_i) begin
    if (cmd_i.ring_init) begin
      ring_q <= '0;
      acc_q  <= ACC_W'(cfg_i.ring_width);
    end else if (cmd_i.ring_step && ring_go) begin
      ring_q <= ring_q + RING_W'(1);
      acc_q  <= acc_q + ACC_W'(cfg_i.ring_width);
    end
  end

  // The angle is forced into the half plane that the sign of y names; with y zero it is set from the sign of x.
  always_comb begin
    fa = ang_q;
    if (y_q == 0) begin
      fa = (x_q < 0) ? HALF_TURN : '0;
    end else if (y_q > 0 && ang_q > HALF_TURN) begin
      fa = (ang_q >= THREE_QTR) ? '0 : HALF_TURN;
    end else if (y_q < 0 && ang_q <= HALF_TURN) begin
      fa = (ang_q < QTR_TURN) ? FULL_ANGLE : HALF_TURN + ANG_W'(1);
    end
    sprod   = SPROD_W'(fa) * SPROD_W'(SECTORS);
    sec_raw = sprod[SPROD_W-1:ANG_W];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sect_en) begin
      sector_q <= (sec_raw > 10'(SECTORS - 1)) ? SECT_W'(SECTORS - 1) : SECT_W'(sec_raw);
    end
  end

  assign bin_addr = ADDR_W'(ring_q * SECTORS + sector_q);
  assign q_addr   = ADDR_W'(qr_q * SECTORS + qs_q);
  assign rd_addr  = (cmd_q == CMD_QUERY) ? q_addr : bin_addr;
  assign wr_addr  = cmd_i.clr_wr ? cmd_i.step[ADDR_W-1:0] : bin_addr;

  always_comb begin
    cur        = (cmd_q == CMD_ADD_SCAN) ? scan_rd : map_rd;
    upd.top    = (z_q > cur.top) ? z_q : cur.top;
    upd.bottom = (z_q < cur.bottom) ? z_q : cur.bottom;
    upd.count  = (cur.count == {CNT_W{1'b1}}) ? cur.count : cur.count + CNT_W'(1);
  end

  assign scan_we = cmd_i.clr_wr || (cmd_i.upd_wr && cmd_q == CMD_ADD_SCAN);
  assign map_we  = cmd_i.clr_wr || (cmd_i.upd_wr && cmd_q == CMD_ADD_MAP);
  assign scan_wd = cmd_i.clr_wr ? BIN_RESET : upd;
  assign map_wd  = cmd_i.clr_wr ? BIN_RESET : upd;

  pbdpf_ram #(.Width(BIN_W), .Depth(NBINS)) u_scan_ram (
    .clk_i   (clk_i),
    .we_i    (scan_we),
    .waddr_i (wr_addr),
    .wdata_i (scan_wd),
    .re_i    (cmd_i.ram_rd),
    .raddr_i (rd_addr),
    .rdata_o (scan_rd)
  );

  pbdpf_ram #(.Width(BIN_W), .Depth(NBINS)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (wr_addr),
    .wdata_i (map_wd),
    .re_i    (cmd_i.ram_rd),
    .raddr_i (rd_addr),
    .rdata_o (map_rd)
  );

  // Spread-ratio test, cross-multiplied so that no division is needed.
  always_comb begin
    md  = SPREAD_W'(map_rd.top) - SPREAD_W'(map_rd.bottom);
    sd  = SPREAD_W'(scan_rd.top) - SPREAD_W'(scan_rd.bottom);
    lo  = (md < sd) ? md : sd;
    hi  = (md < sd) ? sd : md;
    lhs = RATIO_W'(lo) <<< 8;
    rhs = RATIO_W'(signed'({1'b0, cfg_i.ratio_threshold})) * RATIO_W'(hi);
    priority if (scan_rd.count < cfg_i.min_scan_points) begin
      dec = (map_rd.count != '0) ? DEC_MAP : DEC_EMPTY;
    end else if (scan_rd.count != '0 && map_rd.count != '0) begin
      if (lhs < rhs) begin
        if (md >= sd && map_rd.top > cfg_i.bin_height_limit) begin
          dec = DEC_GROUND;
        end else begin
          dec = DEC_MAP;
        end
      end else begin
        dec = DEC_MERGE;
      end
    end else if (scan_rd.count != '0) begin
      dec = DEC_SCAN;
    end else begin
      dec = (map_rd.count != '0) ? DEC_MAP : DEC_EMPTY;
    end
  end

  assign is_add    = (cmd_q == CMD_ADD_SCAN) || (cmd_q == CMD_ADD_MAP);
  assign q_in_grid = (32'(qr_q) < RINGS) && (32'(qs_q) < SECTORS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      accepted_o    <= is_add && ok_q;
      bin_ring_o    <= (is_add && ok_q) ? ring_q : '0;
      bin_sector_o  <= (is_add && ok_q) ? sector_q : '0;
      decision_o    <= (cmd_q == CMD_QUERY && q_in_grid) ? dec : DEC_EMPTY;
      scan_points_o <= (cmd_q == CMD_QUERY && q_in_grid) ? scan_rd.count : '0;
      map_points_o  <= (cmd_q == CMD_QUERY && q_in_grid) ? map_rd.count : '0;
    end
  end

  assign out_valid_o = out_valid_q;

  assign stat_o.command   = cmd_q;
  assign stat_o.in_band   = (z_q < cfg_i.height_upper) && (z_q > cfg_i.height_lower) &&
                            (d2_q <= rr_q);
  assign stat_o.q_in_grid = q_in_grid;
  assign stat_o.ring_done = !ring_go;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

endmodule

### rtl/pbdpf_ctrl.sv
// Controller of the point filter: sequences clearing sweeps, point binning
// and queries over the datapath. Depends on pbdpf_pkg.
`timescale 1ns / 1ps

module pbdpf_ctrl import pbdpf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              sweep_last, iter_last;

  assign sweep_last = (cnt_q == STEP_W'(NBINS - 1));
  assign iter_last  = (cnt_q == STEP_W'(CORDIC_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_BOOT;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = '0;
    unique case (state_q)
      S_BOOT, S_CLR: begin
        cnt_d = cnt_q + STEP_W'(1);
        if (sweep_last) begin
          cnt_d   = '0;
          state_d = (state_q == S_BOOT) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_MULX;
        end
      end
      S_MULX: begin
        // The command is registered by now.
        unique case (stat_i.command)
          CMD_CLEAR: state_d = S_CLR;
          CMD_QUERY: state_d = S_QCHK;
          default:   state_d = S_MULY;
        endcase
      end
      S_MULY:  state_d = S_MULR;
      S_MULR:  state_d = S_CHECK;
      S_CHECK: state_d = stat_i.in_band ? S_ITER : S_DONE;
      S_ITER: begin
        cnt_d = cnt_q + STEP_W'(1);
        if (iter_last) begin
          cnt_d   = '0;
          state_d = S_RING;
        end
      end
      S_RING:  state_d = stat_i.ring_done ? S_SECT : S_RING;
      S_SECT:  state_d = S_RD;
      S_RD:    state_d = S_WR;
      S_WR:    state_d = S_DONE;
      S_QCHK:  state_d = S_DONE;
      S_DONE:  state_d = stat_i.out_free ? S_IDLE : S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.step = cnt_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_BOOT, S_CLR: cmd_o.clr_wr = 1'b1;
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      S_MULX: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_X;
      end
      S_MULY: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_Y;
      end
      S_MULR: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_R;
      end
      S_CHECK: begin
        cmd_o.chk_en    = 1'b1;
        cmd_o.iter_init = 1'b1;
      end
      S_ITER: begin
        cmd_o.iter_step = 1'b1;
        cmd_o.ring_init = iter_last;
      end
      S_RING:  cmd_o.ring_step = 1'b1;
      S_SECT:  cmd_o.sect_en = 1'b1;
      S_RD:    cmd_o.ram_rd = 1'b1;
      S_WR:    cmd_o.upd_wr = 1'b1;
      S_QCHK:  cmd_o.ram_rd = stat_i.q_in_grid;
      S_DONE:  cmd_o.res_load = stat_i.out_free;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ITER |-> cnt_q < STEP_W'(CORDIC_STEPS))
    else $error("CORDIC step count ran past its last step");

  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR || state_q == S_BOOT) |-> cnt_q < STEP_W'(NBINS))
    else $error("clearing sweep address ran past the last bin");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != S_IDLE)
    else $error("accepted beat did not start work");

  a_one_ram_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.clr_wr, cmd_o.upd_wr, cmd_o.ram_rd}))
    else $error("conflicting bin memory operations");
`endif

endmodule
